FILE: sv/projective_vertex_transform_defines.svh
// Assertion macros shared by the projective vertex transform RTL.
`ifndef PROJECTIVE_VERTEX_TRANSFORM_DEFINES_SVH
`define PROJECTIVE_VERTEX_TRANSFORM_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled during reset.
`define PVT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pvt assertion failed");

// Next-cycle implication, sampled on clk, disabled during reset.
`define PVT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pvt assertion failed");

`endif

FILE: sv/pvt_pkg.sv
// Shared constants and types of the projective vertex transform.
package pvt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CW = 67 - FRAC_BITS;
    localparam int NW = CW + FRAC_BITS;
    localparam int QB = 32;

    typedef struct packed {
        logic               is_load;
        logic [3:0]         idx;
        logic signed [31:0] value;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } cmd_t;

    typedef struct packed {
        logic          valid;
        logic          wz;
        logic [2:0]    neg;
        logic [CW-1:0] un_x;
        logic [CW-1:0] un_y;
        logic [CW-1:0] un_z;
        logic [CW-1:0] ud;
    } comp_t;

    typedef struct packed {
        logic [1:0] count;
    } fstat_t;

endpackage

FILE: sv/pvt_front.sv
// Input side: accepts transactions, classifies them and queues them.
module pvt_front
    import pvt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               op,
    input  logic [3:0]         entry_index,
    input  logic signed [31:0] entry_value,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic               pop,
    output logic               q_valid,
    output cmd_t               cmd,
    output fstat_t             fstat
);

    cmd_t       mem_reg [2];
    logic       wr_reg;
    logic       rd_reg;
    logic [1:0] count_reg;
    logic       push;
    cmd_t       in_cmd;

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign cmd      = mem_reg[rd_reg];
    assign fstat.count = count_reg;

    always_comb
    begin
        in_cmd.is_load = !op;
        in_cmd.idx     = entry_index;
        in_cmd.value   = entry_value;
        in_cmd.x       = point_x;
        in_cmd.y       = point_y;
        in_cmd.z       = point_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= !wr_reg;
            end
            if (pop)
            begin
                rd_reg <= !rd_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= in_cmd;
        end
    end

endmodule

FILE: sv/pvt_mac.sv
// Back end, first half: matrix store, products, sums and magnitudes.
module pvt_mac
    import pvt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  q_valid,
    input  cmd_t  cmd,
    input  logic  adv,
    output logic  pop,
    output comp_t comp
);

    logic signed [31:0]     mat_reg  [16];
    logic signed [63:0]     prod_reg [12];
    logic signed [31:0]     e3_reg   [4];
    logic signed [CW-1:0]   h_reg    [4];
    logic signed [CW-1:0]   h_next   [4];
    logic signed [31:0]     pt       [3];
    logic signed [65:0]     s;
    logic                   v1_reg;
    logic                   v2_reg;
    comp_t                  comp_reg;
    comp_t                  comp_next;

    assign pop  = q_valid && adv;
    assign comp = comp_reg;
    assign pt[0] = cmd.x;
    assign pt[1] = cmd.y;
    assign pt[2] = cmd.z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                mat_reg[i] <= (i % 5 == 0) ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
            end
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            comp_reg <= '0;
        end
        else
        begin
            if (pop && cmd.is_load)
            begin
                mat_reg[cmd.idx] <= cmd.value;
            end
            if (adv)
            begin
                v1_reg   <= pop && !cmd.is_load;
                v2_reg   <= v1_reg;
                comp_reg <= comp_next;
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            s = 66'(prod_reg[j]) + 66'(prod_reg[4 + j]) + 66'(prod_reg[8 + j]);
            h_next[j] = CW'(s >>> FRAC_BITS) + CW'(e3_reg[j]);
        end
    end

    always_comb
    begin
        comp_next.valid = v2_reg;
        comp_next.wz    = (h_reg[3] == '0);
        comp_next.ud    = h_reg[3][CW-1] ? CW'(-h_reg[3]) : CW'(h_reg[3]);
        comp_next.un_x  = h_reg[0][CW-1] ? CW'(-h_reg[0]) : CW'(h_reg[0]);
        comp_next.un_y  = h_reg[1][CW-1] ? CW'(-h_reg[1]) : CW'(h_reg[1]);
        comp_next.un_z  = h_reg[2][CW-1] ? CW'(-h_reg[2]) : CW'(h_reg[2]);
        for (int l = 0; l < 3; l++)
        begin
            comp_next.neg[l] = h_reg[l][CW-1] != h_reg[3][CW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    prod_reg[k*4 + j] <= 64'(pt[k]) * 64'(mat_reg[k*4 + j]);
                end
            end
            for (int j = 0; j < 4; j++)
            begin
                e3_reg[j] <= mat_reg[12 + j];
                h_reg[j]  <= h_next[j];
            end
        end
    end

endmodule

FILE: sv/pvt_div.sv
// Back end, second half: pipelined restoring divider, clamp and result register.
module pvt_div
    import pvt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  comp_t              comp,
    input  logic               out_stall,
    output logic               adv,
    output logic               out_valid,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic               w_zero,
    output logic               saturated
);

    logic [CW-1:0] r_reg   [QB+1][3];
    logic [CW-1:0] r_next  [QB+1][3];
    logic [31:0]   lo_reg  [QB+1][3];
    logic [31:0]   lo_next [QB+1][3];
    logic [QB-1:0] q_reg   [QB+1][3];
    logic [QB-1:0] q_next  [QB+1][3];
    logic [2:0]    ovf_reg [QB+1];
    logic [2:0]    ovf_next[QB+1];
    logic [2:0]    neg_reg [QB+1];
    logic [2:0]    neg_next[QB+1];
    logic [CW-1:0] ud_reg  [QB+1];
    logic [CW-1:0] ud_next [QB+1];
    logic          wz_reg  [QB+1];
    logic          wz_next [QB+1];
    logic          v_reg   [QB+1];
    logic [CW-1:0] un      [3];
    logic [NW-1:0] n;
    logic [CW:0]   t;
    logic          ge;
    logic [32:0]   lim;
    logic [32:0]   mag;
    logic          sat_l;
    logic [31:0]   res     [3];
    logic          sat_any;

    logic               out_valid_reg;
    logic signed [31:0] out_x_reg;
    logic signed [31:0] out_y_reg;
    logic signed [31:0] out_z_reg;
    logic               w_zero_reg;
    logic               saturated_reg;

    assign adv       = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;
    assign w_zero    = w_zero_reg;
    assign saturated = saturated_reg;
    assign un[0] = comp.un_x;
    assign un[1] = comp.un_y;
    assign un[2] = comp.un_z;

    always_comb
    begin
        ud_next[0]  = comp.ud;
        wz_next[0]  = comp.wz;
        neg_next[0] = comp.neg;
        for (int l = 0; l < 3; l++)
        begin
            n = NW'(un[l]) << FRAC_BITS;
            ovf_next[0][l] = CW'(n[NW-1:32]) >= comp.ud;
            r_next[0][l]   = CW'(n[NW-1:32]);
            lo_next[0][l]  = n[31:0];
            q_next[0][l]   = '0;
        end
        for (int s = 1; s <= QB; s++)
        begin
            ud_next[s]  = ud_reg[s-1];
            wz_next[s]  = wz_reg[s-1];
            neg_next[s] = neg_reg[s-1];
            ovf_next[s] = ovf_reg[s-1];
            for (int l = 0; l < 3; l++)
            begin
                t  = {r_reg[s-1][l], lo_reg[s-1][l][31]};
                ge = t >= {1'b0, ud_reg[s-1]};
                r_next[s][l]  = ge ? CW'(t - {1'b0, ud_reg[s-1]}) : CW'(t);
                lo_next[s][l] = lo_reg[s-1][l] << 1;
                q_next[s][l]  = {q_reg[s-1][l][QB-2:0], ge};
            end
        end
    end

    always_comb
    begin
        sat_any = 1'b0;
        for (int l = 0; l < 3; l++)
        begin
            lim   = neg_reg[QB][l] ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
            sat_l = ovf_reg[QB][l] || ({1'b0, q_reg[QB][l]} > lim);
            mag   = sat_l ? lim : {1'b0, q_reg[QB][l]};
            res[l] = neg_reg[QB][l] ? 32'(-mag) : mag[31:0];
            sat_any = sat_any || sat_l;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= QB; s++)
            begin
                v_reg[s] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= comp.valid;
            for (int s = 1; s <= QB; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
            out_valid_reg <= v_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s <= QB; s++)
            begin
                ud_reg[s]  <= ud_next[s];
                wz_reg[s]  <= wz_next[s];
                neg_reg[s] <= neg_next[s];
                ovf_reg[s] <= ovf_next[s];
                for (int l = 0; l < 3; l++)
                begin
                    r_reg[s][l]  <= r_next[s][l];
                    lo_reg[s][l] <= lo_next[s][l];
                    q_reg[s][l]  <= q_next[s][l];
                end
            end
            w_zero_reg    <= wz_reg[QB];
            saturated_reg <= wz_reg[QB] ? 1'b0 : sat_any;
            out_x_reg     <= wz_reg[QB] ? 32'sd0 : signed'(res[0]);
            out_y_reg     <= wz_reg[QB] ? 32'sd0 : signed'(res[1]);
            out_z_reg     <= wz_reg[QB] ? 32'sd0 : signed'(res[2]);
        end
    end

endmodule

FILE: sv/projective_vertex_transform.sv
// Top level of the projective vertex transform.
// Usage: the input channel (in_valid / in_stall) takes one transaction per
// cycle while in_stall is low. op = 0 writes matrix entry entry_index with
// entry_value (Q16.16); op = 1 transforms point (point_x, point_y, point_z)
// as [x y z 1] * M and divides x', y', z' by w. A load gives no result; a
// transform gives one result transaction on the output channel (out_valid /
// out_stall). Loads and transforms are carried out strictly in arrival order.
// A transform passes in order through the input queue, the multiply-accumulate
// stages (products, sums, magnitudes) and the divider pipeline, which
// resolves one quotient bit per divide stage.
// Throughput is one transaction per cycle while the receiver does not stall.
// A stall on a valid output freezes the whole back end; the two-entry input
// queue then fills and raises in_stall.
// Reset loads the identity matrix and empties the queue and pipeline.
// A zero w gives a zero vector with w_zero set; clamped outputs set saturated.
`include "projective_vertex_transform_defines.svh"

module projective_vertex_transform
    import pvt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               op,
    input  logic [3:0]         entry_index,
    input  logic signed [31:0] entry_value,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic               w_zero,
    output logic               saturated
);

    logic   pop;
    logic   q_valid;
    logic   adv;
    cmd_t   cmd;
    comp_t  comp;
    fstat_t fstat;

    pvt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .pop         (pop),
        .q_valid     (q_valid),
        .cmd         (cmd),
        .fstat       (fstat)
    );

    pvt_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .cmd     (cmd),
        .adv     (adv),
        .pop     (pop),
        .comp    (comp)
    );

    pvt_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .comp      (comp),
        .out_stall (out_stall),
        .adv       (adv),
        .out_valid (out_valid),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .w_zero    (w_zero),
        .saturated (saturated)
    );

    `PVT_ASSERT_IMP(a_wzero_clean, out_valid && w_zero,
        out_x == 32'sd0 && out_y == 32'sd0 && out_z == 32'sd0 && !saturated)
    `PVT_ASSERT_IMP(a_sat_clamped, out_valid && saturated,
        out_x == 32'sh7FFF_FFFF || out_x == 32'sh8000_0000 ||
        out_y == 32'sh7FFF_FFFF || out_y == 32'sh8000_0000 ||
        out_z == 32'sh7FFF_FFFF || out_z == 32'sh8000_0000)
    `PVT_ASSERT_IMP(a_queue_bound, 1'b1, fstat.count != 2'd3)
    `PVT_ASSERT_IMP(a_empty_no_pop, fstat.count == 2'd0, !pop)
    `PVT_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_x))

endmodule
